[src/sha256md_pkg.sv]
// Shared types and constants for the SHA-256 message digest block.
// No dependencies; used by every module under src.

package sha256md_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned RoundCount = 64;
  localparam int unsigned DigestWords = 8;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUNDS,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Controls for the message schedule
  typedef struct packed {
    logic push;   // shift in a message or padding word
    logic step;   // shift in the next expanded word
  } sched_ctrl_t;

  // Controls for the round unit
  typedef struct packed {
    logic load;   // take the working variables from the chain value
    logic step;   // run one compression round
  } round_ctrl_t;

  localparam logic [31:0] PadMarker = 32'h8000_0000;

  localparam logic [31:0] InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [RoundCount] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    return RoundK[idx];
  endfunction

endpackage

[src/sha256md_sched.sv]
// SHA-256 message schedule: 16-word shift line that gathers a block and
// then expands it one word per round. Depends on sha256md_pkg.

module sha256md_sched (
  input  logic                       clk,
  input  sha256md_pkg::sched_ctrl_t  ctrl,
  input  logic [31:0]                push_data,
  output logic [31:0]                w_out
);

  logic [31:0] w [sha256md_pkg::BlockWords];
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] w_new;

  // W[t+16] = W[t] + s0(W[t+1]) + W[t+9] + s1(W[t+14])
  assign s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
  assign w_new = w[0] + s0 + w[9] + s1;

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= ctrl.push ? push_data : w_new;
    end
  end

  assign w_out = w[0];

endmodule

[src/sha256md_round.sv]
// SHA-256 round unit: working variables a..h and one round per step.
// Depends on sha256md_pkg for the round constants.

module sha256md_round (
  input  logic                       clk,
  input  sha256md_pkg::round_ctrl_t  ctrl,
  input  logic [7:0][31:0]           chain,
  input  logic [5:0]                 round_idx,
  input  logic [31:0]                w_in,
  output logic [7:0][31:0]           vars
);

  logic [31:0] a, b, c, e, f, g, h;
  logic [31:0] big0, big1, ch, maj, t1, t2;

  assign a = vars[0];
  assign b = vars[1];
  assign c = vars[2];
  assign e = vars[4];
  assign f = vars[5];
  assign g = vars[6];
  assign h = vars[7];

  assign big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ch   = (e & f) ^ (~e & g);
  assign t1   = h + big1 + ch + sha256md_pkg::round_k(round_idx) + w_in;
  assign big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign maj  = (a & b) ^ (a & c) ^ (b & c);
  assign t2   = big0 + maj;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      vars <= chain;
    end else if (ctrl.step) begin
      vars[7] <= g;
      vars[6] <= f;
      vars[5] <= e;
      vars[4] <= vars[3] + t1;
      vars[3] <= c;
      vars[2] <= b;
      vars[1] <= a;
      vars[0] <= t1 + t2;
    end
  end

endmodule

[src/sha256_message_digest.sv]
// SHA-256 message digest. Feed the message as 32-bit words, earliest byte in
// bits 31..24, and mark the last word with tlast; tuser then gives how many of
// its leading bytes are valid (0..4, larger counts act as 4; on other words
// it is ignored). The block pads the message itself and then sends the eight
// digest words, first word first, with tlast on the eighth, after which it is
// ready for the next message. Every 16th word (counting padding words)
// starts a compression: 64 rounds through the single round unit, then a
// fold of the result into the chain value; no words are taken meanwhile.
// On the last word the block adds its padding words one per cycle, pausing
// for a compression whenever a block fills (one extra block when fewer than
// two words are left), then holds each digest word until it is taken. tready
// is low throughout.
// Depends on sha256md_pkg, sha256md_sched and sha256md_round.

module sha256_message_digest (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] message_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
  input  logic        s_axis_tlast,   // final_word
  // digest stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast    // last_digest
);

  sha256md_pkg::state_t state, state_next;

  logic [7:0][31:0] chain;
  logic [7:0][31:0] vars;
  logic [63:0]      msg_bits;
  logic [3:0]       word_pos;
  logic [5:0]       round_cnt;
  logic [2:0]       emit_cnt;
  logic             need_marker;   // 0x80 byte still owed as a whole word
  logic             len_hi_sent;   // upper length word is in the block
  logic             pad_active;    // padding of a final word under way
  logic             pad_done;      // length fully pushed; digest follows

  sha256md_pkg::sched_ctrl_t sched_ctrl;
  sha256md_pkg::round_ctrl_t round_ctrl;

  logic        push_en;
  logic [31:0] push_data;
  logic [31:0] w_cur;
  logic [2:0]  count_clamp;
  logic [31:0] tail_word;
  logic        in_fire;
  logic        out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign count_clamp = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;

  // Last word with the 0x80 byte placed right after the valid bytes
  always_comb begin
    case (count_clamp)
      3'd0:    tail_word = sha256md_pkg::PadMarker;
      3'd1:    tail_word = {s_axis_tdata[31:24], 24'h80_0000};
      3'd2:    tail_word = {s_axis_tdata[31:16], 16'h8000};
      3'd3:    tail_word = {s_axis_tdata[31:8], 8'h80};
      default: tail_word = s_axis_tdata;
    endcase
  end

  // Sequencer: next state and datapath controls
  always_comb begin
    state_next      = state;
    push_en         = 1'b0;
    push_data       = s_axis_tdata;
    round_ctrl.step = 1'b0;
    s_axis_tready   = 1'b0;
    m_axis_tvalid   = 1'b0;
    case (state)
      sha256md_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          push_en   = 1'b1;
          push_data = s_axis_tlast ? tail_word : s_axis_tdata;
          if (word_pos == 4'd15) begin
            state_next = sha256md_pkg::ST_ROUNDS;
          end else if (s_axis_tlast) begin
            state_next = sha256md_pkg::ST_PAD;
          end
        end
      end
      sha256md_pkg::ST_PAD: begin
        push_en = 1'b1;
        if (need_marker) begin
          push_data = sha256md_pkg::PadMarker;
        end else if (len_hi_sent) begin
          push_data = msg_bits[31:0];
        end else if (word_pos == 4'd14) begin
          push_data = msg_bits[63:32];
        end else begin
          push_data = '0;
        end
        if (word_pos == 4'd15) begin
          state_next = sha256md_pkg::ST_ROUNDS;
        end
      end
      sha256md_pkg::ST_ROUNDS: begin
        round_ctrl.step = 1'b1;
        if (round_cnt == 6'd63) begin
          state_next = sha256md_pkg::ST_FOLD;
        end
      end
      sha256md_pkg::ST_FOLD: begin
        if (pad_done) begin
          state_next = sha256md_pkg::ST_EMIT;
        end else if (pad_active) begin
          state_next = sha256md_pkg::ST_PAD;
        end else begin
          state_next = sha256md_pkg::ST_IDLE;
        end
      end
      sha256md_pkg::ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready && emit_cnt == 3'd7) begin
          state_next = sha256md_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256md_pkg::ST_IDLE;
    endcase
    // block fills on this push: pick up the chain value for the rounds
    round_ctrl.load = push_en && (word_pos == 4'd15);
  end

  assign sched_ctrl.push = push_en;
  assign sched_ctrl.step = round_ctrl.step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256md_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha256md_pkg::InitHash[i];
      end
      msg_bits    <= '0;
      word_pos    <= '0;
      round_cnt   <= '0;
      emit_cnt    <= '0;
      need_marker <= 1'b0;
      len_hi_sent <= 1'b0;
      pad_active  <= 1'b0;
      pad_done    <= 1'b0;
    end else begin
      if (push_en) begin
        word_pos <= word_pos + 4'd1;
      end
      if (in_fire) begin
        if (s_axis_tlast) begin
          msg_bits    <= msg_bits + {58'd0, count_clamp, 3'd0};
          need_marker <= (count_clamp == 3'd4);
          pad_active  <= 1'b1;
        end else begin
          msg_bits <= msg_bits + 64'd32;
        end
      end
      if (state == sha256md_pkg::ST_PAD) begin
        if (need_marker) begin
          need_marker <= 1'b0;
        end else if (len_hi_sent) begin
          pad_done <= 1'b1;
        end else if (word_pos == 4'd14) begin
          len_hi_sent <= 1'b1;
        end
      end
      if (round_ctrl.step) begin
        round_cnt <= round_cnt + 6'd1;
      end
      if (state == sha256md_pkg::ST_FOLD) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      // digest leaves from chain[0]; refill from the top with the initial
      // hash so the chain is back at its start value after eight words
      if (out_fire) begin
        for (int i = 0; i < 7; i++) begin
          chain[i] <= chain[i+1];
        end
        chain[7] <= sha256md_pkg::InitHash[emit_cnt];
        emit_cnt <= emit_cnt + 3'd1;
        if (emit_cnt == 3'd7) begin
          msg_bits    <= '0;
          len_hi_sent <= 1'b0;
          pad_active  <= 1'b0;
          pad_done    <= 1'b0;
        end
      end
    end
  end

  sha256md_sched u_sched (
    .clk       (clk),
    .ctrl      (sched_ctrl),
    .push_data (push_data),
    .w_out     (w_cur)
  );

  sha256md_round u_round (
    .clk       (clk),
    .ctrl      (round_ctrl),
    .chain     (chain),
    .round_idx (round_cnt),
    .w_in      (w_cur),
    .vars      (vars)
  );

  assign m_axis_tdata = chain[0];
  assign m_axis_tlast = (emit_cnt == 3'd7);

  // never taking words while a digest is pending
  assert property (@(posedge clk) disable iff (rst) !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while digest pending");

  // round counter only moves inside a compression
  assert property (@(posedge clk) disable iff (rst)
    (state != sha256md_pkg::ST_ROUNDS) |-> (round_cnt == 6'd0))
    else $error("round counter out of step");

  // digest only goes out on a block boundary
  assert property (@(posedge clk) disable iff (rst)
    (state == sha256md_pkg::ST_EMIT) |-> (word_pos == 4'd0 && pad_done))
    else $error("digest started mid-block");

  // after the eighth digest word the block takes input again
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after digest");

endmodule

[test/sha256md_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for sha256_message_digest: watches both streams, keeps its own
// SHA-256 hash state and checks every digest word in order.
// Depends on sha256md_pkg for the hash constants.

module sha256md_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] message_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
  input  logic        s_axis_tlast,   // final_word
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] digest_word
  input  logic        m_axis_tlast,   // last_digest
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic [31:0]  hash_state [sha256md_pkg::DigestWords];
  logic [31:0]  block_words [sha256md_pkg::BlockWords];
  int unsigned  fill_pos;
  logic [63:0]  msg_bits_seen;
  digest_beat_t expected_digest_q [$];
  int           mismatches = 0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void load_initial_hash();
    for (int i = 0; i < sha256md_pkg::DigestWords; i++)
      hash_state[i] = sha256md_pkg::InitHash[i];
  endfunction

  // one full SHA-256 compression of block_words into hash_state
  function automatic void compress_block();
    logic [31:0] w [sha256md_pkg::RoundCount];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int i = 16; i < sha256md_pkg::RoundCount; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < sha256md_pkg::RoundCount; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + sha256md_pkg::RoundK[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void absorb_word(input logic [31:0] w);
    block_words[fill_pos] = w;
    fill_pos++;
    if (fill_pos == sha256md_pkg::BlockWords) begin
      compress_block();
      fill_pos = 0;
    end
  endfunction

  // one accepted input word; the last word of a message pads and queues the digest
  function automatic void absorb_input(input logic [31:0] data, input logic [2:0] cnt,
                                       input logic last);
    int unsigned  nb;
    logic [31:0]  keep;
    digest_beat_t beat;
    nb = (cnt > 3'd4) ? 4 : cnt;
    if (!last) begin
      absorb_word(data);
      msg_bits_seen += 64'd32;
      return;
    end
    msg_bits_seen += 64'(nb * 8);
    if (nb == 4) begin
      absorb_word(data);
      absorb_word(sha256md_pkg::PadMarker);
    end else begin
      keep = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
      absorb_word((data & keep) | (32'h80 << (24 - 8 * nb)));
    end
    // no room left for the length: close this block with zeros
    if (fill_pos > 14) begin
      while (fill_pos != 0) absorb_word(32'h0);
    end
    while (fill_pos < 14) absorb_word(32'h0);
    absorb_word(msg_bits_seen[63:32]);
    absorb_word(msg_bits_seen[31:0]);
    for (int k = 0; k < sha256md_pkg::DigestWords; k++) begin
      beat.word = hash_state[k];
      beat.last = (k == sha256md_pkg::DigestWords - 1);
      expected_digest_q.insert(expected_digest_q.size(), beat);
    end
    load_initial_hash();
    msg_bits_seen = '0;
    fill_pos = 0;
  endfunction

  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      load_initial_hash();
      msg_bits_seen = '0;
      fill_pos = 0;
      expected_digest_q.delete();
    end else begin
      // results first: a digest word never stems from a word taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_digest_q.size() == 0) begin
          $display("%0t: digest word %h last %b arrived with none expected",
                   $time, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_digest_q.pop_front();
          if (m_axis_tdata !== want.word) begin
            $display("%0t: digest word expected %h, got %h", $time, want.word, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last_digest expected %b, got %b", $time, want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
    errors <= mismatches;
    outstanding <= expected_digest_q.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Top of the sha256_message_digest testbench: clock, reset, message and
// backpressure stimulus, watchdog and verdict. Depends on sha256md_pkg,
// sha256md_checker and the block itself.

module tb;

  localparam int MessageWordTarget = 320;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] message_word
  logic [2:0]  s_axis_tuser = '0;   // [2:0] byte_count
  logic        s_axis_tlast = 1'b0; // final_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] digest_word
  logic        m_axis_tlast;        // last_digest

  int errors;
  int outstanding;
  int words_sent = 0;
  int stall_cycles = 0;
  int ready_run = 0;
  bit sender_quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  sha256_message_digest uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  sha256md_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .outstanding   (outstanding)
  );

  // digest side backpressure: runs of ready and stall, with long open stretches
  always @(posedge clk) begin
    int r;
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        m_axis_tready <= 1'b1;
        ready_run <= $urandom_range(30, 80);
      end else if (r < 75) begin
        m_axis_tready <= 1'b1;
        ready_run <= $urandom_range(0, 3);
      end else if (r < 95) begin
        m_axis_tready <= 1'b0;
        ready_run <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        ready_run <= $urandom_range(10, 50);
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("sha256_message_digest verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] random_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h0;
    if (r < 16) return 32'hffff_ffff;
    return $urandom;
  endfunction

  // offer one word, wait for it to be taken, then maybe leave a gap
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic last);
    int r;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= cnt;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every queued digest word has come out
  task automatic wait_for_digests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_message(input int body_words, input logic [2:0] last_cnt);
    for (int i = 0; i < body_words; i++)
      send_word(random_data(), 3'($urandom_range(0, 7)), 1'b0);
    send_word(random_data(), last_cnt, 1'b1);
  endtask

  initial begin
    int r;
    int body;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message with junk in the unused bytes
    send_word(32'hdead_beef, 3'd0, 1'b1);
    // "abc", junk in the fourth byte
    send_word(32'h6162_63ff, 3'd3, 1'b1);
    // short count on a non-final word is ignored
    send_word(32'hffff_ffff, 3'd1, 1'b0);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    // counts above four act as four
    send_word(32'hffff_ffff, 3'd5, 1'b1);
    send_word(32'h0000_0000, 3'd6, 1'b1);
    send_word(32'ha5a5_a5a5, 3'd7, 1'b1);
    // one and two valid bytes
    send_word(32'h1234_5678, 3'd1, 1'b1);
    send_word(32'h9abc_def0, 3'd2, 1'b1);
    send_word(32'h0000_0000, 3'd0, 1'b0);
    send_word(32'hffff_ffff, 3'd7, 1'b0);
    send_word(32'h0f0f_0f0f, 3'd2, 1'b1);
    wait_for_digests();

    // random messages; lengths near 14 words force the extra padding block
    while (words_sent < MessageWordTarget) begin
      r = $urandom_range(0, 99);
      if (r < 10) body = 0;
      else if (r < 30) body = $urandom_range(12, 15);
      else if (r < 40) body = $urandom_range(16, 40);
      else body = $urandom_range(1, 11);
      sender_quiet = ($urandom_range(0, 3) == 0);
      send_message(body, 3'($urandom_range(0, 7)));
      if ($urandom_range(0, 9) == 0) wait_for_digests();
    end
    sender_quiet = 1'b0;

    wait_for_digests();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("sha256_message_digest verification clean");
    end else begin
      $display("sha256_message_digest verification failed");
    end
    $finish;
  end

endmodule
